FILE: hw/rtl/chd_pkg.sv
`default_nettype none

package chd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int BYTE_BITS = 8;
   localparam int RSP_USER_BITS = 3;

   localparam int USR_PAYLOAD = 0;
   localparam int USR_DONE    = 1;
   localparam int USR_ERROR   = 2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] HEX_TEN  = 8'd10;
   localparam logic [4:0] NOT_HEX  = 5'd16;

   // 0..15 for a hex digit, NOT_HEX otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] d;
      if (c inside {[CH_0:CH_9]}) begin
         d = 5'(c - CH_0);
      end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
         d = 5'(c - CH_LO_A + HEX_TEN);
      end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
         d = 5'(c - CH_UP_A + HEX_TEN);
      end else begin
         d = NOT_HEX;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/http_chunked_decoder.sv
// Channel  Dir  tdata          tuser                                    tlast
// req      in   in_byte        new_message                              -
// rsp      out  payload_byte   payload_valid, message_done, frame_error chunk_last
//
// One byte per cycle unless rsp stalls: the parser state updates at each req
// transfer and the result lands in a single output register in the next cycle.
// req_tready is high whenever the output register is empty or being drained,
// so a stalled rsp side holds at most one result.
// Synchronous reset clears the parser (size line, hex digits, size zero).
`default_nettype none

module http_chunked_decoder import chd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [BYTE_BITS-1:0]     req_tdata,   // in_byte
   input  logic [0:0]               req_tuser,   // new_message
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [BYTE_BITS-1:0]     rsp_tdata,   // payload_byte
   output logic                     rsp_tlast,   // chunk_last
   output logic [RSP_USER_BITS-1:0] rsp_tuser    // payload_valid, message_done, frame_error
);

   typedef enum logic [1:0] {MODE_SIZE, MODE_DATA, MODE_DONE, MODE_ERR} mode_type;
   typedef enum logic [2:0] {POS_HEX, POS_EXT, POS_LF, POS_TCR, POS_TLF} pos_type;

   mode_type                 mode_ff, mode_in, mode_cur;
   pos_type                  pos_ff, pos_in, pos_cur;
   logic [SIZE_BITS-1:0]     rem_ff, rem_in, rem_cur, rem_dec;
   logic [4:0]               digit;
   logic                     accept;
   logic                     valid_in, last_in;
   logic [BYTE_BITS-1:0]     byte_in;

   logic                     rsp_valid_ff;
   logic [BYTE_BITS-1:0]     rsp_data_ff;
   logic                     rsp_last_ff;
   logic [RSP_USER_BITS-1:0] rsp_user_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      mode_cur = req_tuser[0] ? MODE_SIZE : mode_ff;
      pos_cur  = req_tuser[0] ? POS_HEX : pos_ff;
      rem_cur  = req_tuser[0] ? '0 : rem_ff;
      digit    = hex_value(req_tdata);
      rem_dec  = rem_cur - SIZE_BITS'(1);
      mode_in  = mode_cur;
      pos_in   = pos_cur;
      rem_in   = rem_cur;
      valid_in = 1'b0;
      last_in  = 1'b0;
      byte_in  = '0;
      case (mode_cur)
         MODE_SIZE: begin
            case (pos_cur)
               POS_HEX: begin
                  if (digit != NOT_HEX) begin
                     if (rem_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                        mode_in = MODE_ERR;
                     end else begin
                        rem_in = (rem_cur << 4) | SIZE_BITS'(digit[3:0]);
                     end
                  end else if (req_tdata == CH_CR) begin
                     pos_in = POS_LF;
                  end else if (req_tdata == CH_SEMI) begin
                     pos_in = POS_EXT;
                  end else begin
                     mode_in = MODE_ERR;
                  end
               end
               POS_EXT: begin
                  if (req_tdata == CH_CR) pos_in = POS_LF;
               end
               POS_LF: begin
                  if (req_tdata != CH_LF) begin
                     mode_in = MODE_ERR;
                  end else begin
                     pos_in  = POS_HEX;
                     mode_in = (rem_cur == '0) ? MODE_DONE : MODE_DATA;
                  end
               end
               POS_TCR: begin
                  if (req_tdata == CH_CR) pos_in = POS_TLF;
                  else mode_in = MODE_ERR;
               end
               POS_TLF: begin
                  if (req_tdata == CH_LF) pos_in = POS_HEX;
                  else mode_in = MODE_ERR;
               end
               default: begin
                  mode_in = MODE_ERR;
               end
            endcase
         end
         MODE_DATA: begin
            valid_in = 1'b1;
            byte_in  = req_tdata;
            rem_in   = rem_dec;
            if (rem_dec == '0) begin
               last_in = 1'b1;
               mode_in = MODE_SIZE;
               pos_in  = POS_TCR;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SIZE;
         pos_ff       <= POS_HEX;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            pos_ff       <= pos_in;
            rem_ff       <= rem_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_data_ff              <= byte_in;
         rsp_last_ff              <= last_in;
         rsp_user_ff[USR_PAYLOAD] <= valid_in;
         rsp_user_ff[USR_DONE]    <= (mode_in == MODE_DONE);
         rsp_user_ff[USR_ERROR]   <= (mode_in == MODE_ERR);
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/chd_checker.sv
`default_nettype none

module chd_checker import chd_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [BYTE_BITS-1:0]     rsp_tdata,
   input wire logic                     rsp_tlast,
   input wire logic [RSP_USER_BITS-1:0] rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // an empty output register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with no result pending");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[USR_PAYLOAD])
      else $error("chunk_last without payload");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tuser) <= 1)
      else $error("payload, done and error flags overlap");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[USR_PAYLOAD] |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("non-payload transfer carries data");

endmodule

bind http_chunked_decoder chd_checker u_chd_checker (.*);

`default_nettype wire
